[design/lrc_pkg.sv]
// shared types and constants of the line rasterizer with clip
`default_nettype none

package lrc_pkg;

  localparam int unsigned CoordW     = 6;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned ErrW       = 8;
  localparam int unsigned MaxCanvas  = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [CoordW-1:0] coord_t;

  // register map, one 32-bit word per register
  typedef enum logic {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } lrc_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lrc_state_e;

  // input beat
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } lrc_seg_in_t;

  // output beat
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   visible;
    logic   last_pixel;
  } lrc_pix_t;

  // segment after setup, as held in the queue
  typedef struct packed {
    coord_t                     x0;
    coord_t                     y0;
    coord_t                     xe;
    coord_t                     ye;
    coord_t                     dx;
    coord_t                     dy;
    logic                       sx;
    logic                       sy;
    logic signed [ErrW-1:0]     err0;
  } lrc_seg_t;

endpackage

`default_nettype wire

[design/lrc_front.sv]
// front end: accepts segments and works out deltas, directions and start error
`default_nettype none

module lrc_front (
  input  wire                 lrc_pkg::lrc_seg_in_t in_data_i,
  output lrc_pkg::lrc_seg_t   seg_o
);

  lrc_pkg::coord_t dx;
  lrc_pkg::coord_t dy;
  logic            sx;
  logic            sy;

  always_comb begin
    sx = (in_data_i.start_x < in_data_i.end_x);
    sy = (in_data_i.start_y < in_data_i.end_y);
    dx = sx ? (in_data_i.end_x - in_data_i.start_x) : (in_data_i.start_x - in_data_i.end_x);
    dy = sy ? (in_data_i.end_y - in_data_i.start_y) : (in_data_i.start_y - in_data_i.end_y);
  end

  always_comb begin
    seg_o.x0   = in_data_i.start_x;
    seg_o.y0   = in_data_i.start_y;
    seg_o.xe   = in_data_i.end_x;
    seg_o.ye   = in_data_i.end_y;
    seg_o.dx   = dx;
    seg_o.dy   = dy;
    seg_o.sx   = sx;
    seg_o.sy   = sy;
    seg_o.err0 = $signed({2'b00, dx}) - $signed({2'b00, dy});
  end

endmodule

`default_nettype wire

[design/lrc_queue.sv]
// short segment queue between front end and stepper
`default_nettype none

module lrc_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  wire               lrc_pkg::lrc_seg_t push_data_i,
  output logic              full_o,
  input  wire               pop_i,
  output logic              valid_o,
  output lrc_pkg::lrc_seg_t pop_data_o
);

  lrc_pkg::lrc_seg_t mem_q [lrc_pkg::QueueDepth];

  logic [lrc_pkg::QueuePtrW-1:0] wptr_q, wptr_d;
  logic [lrc_pkg::QueuePtrW-1:0] rptr_q, rptr_d;
  logic [lrc_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o     = (cnt_q == lrc_pkg::QueueCntW'(lrc_pkg::QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointers wrap at the queue depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == lrc_pkg::QueuePtrW'(lrc_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == lrc_pkg::QueuePtrW'(lrc_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[design/lrc_back.sv]
// back end: bresenham stepper with clip flag and output register
`default_nettype none

module lrc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 seg_valid_i,
  input  wire                 lrc_pkg::lrc_seg_t seg_i,
  output logic                seg_pop_o,
  input  wire  [lrc_pkg::CfgW-1:0] width_i,
  input  wire  [lrc_pkg::CfgW-1:0] height_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output lrc_pkg::lrc_pix_t   out_data_o
);

  lrc_pkg::lrc_state_e st_q, st_d;
  lrc_pkg::lrc_seg_t   seg_q;
  lrc_pkg::coord_t     cur_x_q;
  lrc_pkg::coord_t     cur_y_q;
  logic signed [lrc_pkg::ErrW-1:0] err_q;
  logic                out_valid_q;
  lrc_pkg::lrc_pix_t   out_q;

  logic                adv;
  logic                done;
  logic                load;
  logic signed [lrc_pkg::ErrW:0]   e2;
  logic                step_x;
  logic                step_y;
  logic signed [lrc_pkg::ErrW-1:0] err_nx;
  logic                vis;

  assign adv  = (st_q == lrc_pkg::ST_RUN) && (!out_valid_q || out_ready_i);
  assign done = (cur_x_q == seg_q.xe) && (cur_y_q == seg_q.ye);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      lrc_pkg::ST_IDLE: begin
        if (seg_valid_i) begin
          st_d = lrc_pkg::ST_RUN;
        end
      end
      lrc_pkg::ST_RUN: begin
        if (adv && done) begin
          st_d = lrc_pkg::ST_IDLE;
        end
      end
      default: st_d = lrc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load = 1'b0;
    case (st_q)
      lrc_pkg::ST_IDLE: load = seg_valid_i;
      lrc_pkg::ST_RUN:  load = 1'b0;
      default:          load = 1'b0;
    endcase
  end

  assign seg_pop_o = load;

  // error step: compare twice the error against both deltas
  always_comb begin
    e2     = {err_q, 1'b0};
    step_x = (e2 >= -$signed({3'b000, seg_q.dy}));
    step_y = (e2 <= $signed({3'b000, seg_q.dx}));
    err_nx = err_q - (step_x ? $signed({2'b00, seg_q.dy}) : '0)
                   + (step_y ? $signed({2'b00, seg_q.dx}) : '0);
  end

  assign vis = (32'(cur_x_q) < 32'(width_i))  && (32'(cur_x_q) < lrc_pkg::MaxCanvas) &&
               (32'(cur_y_q) < 32'(height_i)) && (32'(cur_y_q) < lrc_pkg::MaxCanvas);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= lrc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seg_q   <= seg_i;
      cur_x_q <= seg_i.x0;
      cur_y_q <= seg_i.y0;
      err_q   <= seg_i.err0;
    end else if (adv && !done) begin
      err_q <= err_nx;
      if (step_x) begin
        cur_x_q <= seg_q.sx ? cur_x_q + 1'b1 : cur_x_q - 1'b1;
      end
      if (step_y) begin
        cur_y_q <= seg_q.sy ? cur_y_q + 1'b1 : cur_y_q - 1'b1;
      end
    end
    if (adv) begin
      out_q.pixel_x    <= cur_x_q;
      out_q.pixel_y    <= cur_y_q;
      out_q.visible    <= vis;
      out_q.last_pixel <= done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the end point returns the stepper to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && done) |=> (st_q == lrc_pkg::ST_IDLE))
    else $error("stepper did not stop after the end point");

  // every step that is not the end moves the pixel
  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !done) |=> ((cur_x_q != $past(cur_x_q)) || (cur_y_q != $past(cur_y_q))))
    else $error("bresenham step did not move");

  // a new beat is only produced by a running segment
  a_out_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == lrc_pkg::ST_RUN))
    else $error("output beat without a running segment");

endmodule

`default_nettype wire

[design/line_rasterizer_with_clip_unit.sv]
// top level: apb registers, front end, segment queue and bresenham stepper
// a segment accepted at the input is written into the queue and loaded from there by the stepper; its first
//   pixel beat then shows on the output from the stepper's output register
// throughput: one pixel beat per cycle while the sink is ready; the stepper passes through idle to load
//   each segment, so it takes a new segment only after the last pixel of the one before; the stepper sets it
// a two-entry queue of set-up segments lets input and output stall independently
// reset (asynchronous, active low) empties the queue, idles the stepper, canvas to 64 by 64
`default_nettype none

module line_rasterizer_with_clip_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [lrc_pkg::AddrW-1:0]      paddr,
  input  wire  [lrc_pkg::DataW-1:0]      pwdata,
  output logic [lrc_pkg::DataW-1:0]      prdata,
  output logic                           pready,
  // segment input
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  lrc_pkg::lrc_seg_in_t     in_data_i,
  // pixel output
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output lrc_pkg::lrc_pix_t              out_data_o
);

  logic [lrc_pkg::CfgW-1:0] width_q;
  logic [lrc_pkg::CfgW-1:0] height_q;
  lrc_pkg::lrc_reg_e        reg_sel;
  logic                     cfg_wr;

  lrc_pkg::lrc_seg_t        front_seg;
  lrc_pkg::lrc_seg_t        queue_seg;
  logic                     queue_full;
  logic                     queue_valid;
  logic                     queue_pop;

  // register decode: word index is the address above the byte lanes
  assign pready  = 1'b1;
  assign reg_sel = lrc_pkg::lrc_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lrc_pkg::CfgW'(64);
      height_q <= lrc_pkg::CfgW'(64);
    end else if (cfg_wr) begin
      case (reg_sel)
        lrc_pkg::REG_CANVAS_WIDTH:  width_q  <= pwdata[lrc_pkg::CfgW-1:0];
        lrc_pkg::REG_CANVAS_HEIGHT: height_q <= pwdata[lrc_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (reg_sel)
      lrc_pkg::REG_CANVAS_WIDTH:  prdata = lrc_pkg::DataW'(width_q);
      lrc_pkg::REG_CANVAS_HEIGHT: prdata = lrc_pkg::DataW'(height_q);
      default:                    prdata = '0;
    endcase
  end

  // front end sets up the segment; it is taken whenever the queue has room
  assign in_ready_o = !queue_full;

  lrc_front u_front (
    .in_data_i (in_data_i),
    .seg_o     (front_seg)
  );

  lrc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_seg),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_seg)
  );

  // back end walks the line one pixel per cycle, while the sink is ready, into its output register
  lrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_valid_i (queue_valid),
    .seg_i       (queue_seg),
    .seg_pop_o   (queue_pop),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[sim/line_rasterizer_with_clip_unit_tb.sv]
// testbench for the line rasterizer with clip: directed table, then random segments
module line_rasterizer_with_clip_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrc_pkg::*;

  // run shape
  localparam int unsigned NumPhases       = 8;
  localparam int unsigned PhaseItems      = 58;
  localparam int unsigned PausePhase      = 2;
  localparam int unsigned MaxPixels       = 64;
  localparam int unsigned LongStallAfter  = 1500;
  localparam int unsigned LongStallCycles = 500;
  localparam int unsigned EndSettle       = 80;
  localparam int unsigned MaxReports      = 40;
  // the limit lies well above the slowest legal run, so this only catches a hang
  localparam int unsigned CycleLimit      = 4_000_000;
  localparam int unsigned DirRows         = 27;

  // directed table rows: either a segment or a register write
  typedef enum logic {
    ROW_SEG,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    lrc_reg_e          reg_sel;
    logic [CfgW-1:0]   value;
    lrc_seg_in_t       seg;
    logic              typed;   // pix holds the expected beat, no prediction needed
    lrc_pix_t          pix;
  } stim_row_t;

  // dut ports
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  lrc_seg_in_t       in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  lrc_pix_t          out_data_o;

  // canvas limits as the dut should hold them
  logic [CfgW-1:0]   canvas_w;
  logic [CfgW-1:0]   canvas_h;

  // pixel beats still owed by the dut, oldest first
  lrc_pix_t          pending_pix_q [$];
  lrc_pix_t          want;

  int unsigned       fail_count  = 0;
  int unsigned       beats_taken = 0;
  int unsigned       cycle_count = 0;

  // input side pacing: gap before the next segment, and whether valid stays up
  int unsigned       gap_ahead   = 0;
  bit                valid_held  = 1'b0;

  line_rasterizer_with_clip_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // table helpers

  function automatic stim_row_t seg_row(int sx, int sy, int ex, int ey);
    stim_row_t r;
    r = '0;
    r.kind        = ROW_SEG;
    r.seg.start_x = coord_t'(sx);
    r.seg.start_y = coord_t'(sy);
    r.seg.end_x   = coord_t'(ex);
    r.seg.end_y   = coord_t'(ey);
    return r;
  endfunction

  // single point: exactly one beat, always the last one
  function automatic stim_row_t pt_row(int x, int y, logic vis);
    stim_row_t r;
    r = seg_row(x, y, x, y);
    r.typed          = 1'b1;
    r.pix.pixel_x    = coord_t'(x);
    r.pix.pixel_y    = coord_t'(y);
    r.pix.visible    = vis;
    r.pix.last_pixel = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(lrc_reg_e sel, int v);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_sel = sel;
    r.value   = CfgW'(v);
    return r;
  endfunction

  // directed part: extremes, diagonals, axis lines, shallow and steep lines, canvas edge cases
  stim_row_t dir_table [DirRows] = '{
    pt_row(0, 0, 1'b1),                    // right after reset, default canvas
    pt_row(63, 63, 1'b1),                  // far corner visible at 64x64
    pt_row(42, 21, 1'b1),                  // alternating coordinate bits
    seg_row(0, 0, 63, 63),                 // full diagonal
    seg_row(63, 0, 0, 63),                 // anti-diagonal, x stepping down
    seg_row(0, 0, 63, 0),                  // full horizontal
    seg_row(63, 63, 0, 63),                // horizontal, reversed
    seg_row(0, 63, 0, 0),                  // full vertical, y stepping down
    seg_row(21, 42, 42, 21),
    seg_row(5, 40, 62, 3),                 // shallow
    seg_row(10, 20, 13, 60),               // steep
    cfg_row(REG_CANVAS_WIDTH, 0),          // zero width hides everything
    pt_row(5, 5, 1'b0),
    seg_row(0, 10, 20, 10),
    cfg_row(REG_CANVAS_WIDTH, 127),        // oversized acts as full size
    cfg_row(REG_CANVAS_HEIGHT, 0),         // zero height hides everything
    pt_row(0, 0, 1'b0),
    cfg_row(REG_CANVAS_HEIGHT, 127),
    pt_row(63, 63, 1'b1),                  // both oversized: all visible
    cfg_row(REG_CANVAS_WIDTH, 1),          // one pixel canvas
    cfg_row(REG_CANVAS_HEIGHT, 1),
    pt_row(0, 0, 1'b1),
    pt_row(1, 0, 1'b0),
    seg_row(0, 0, 3, 5),
    cfg_row(REG_CANVAS_WIDTH, 64),
    cfg_row(REG_CANVAS_HEIGHT, 65),        // just above the clamp
    seg_row(63, 0, 60, 63)
  };

  // ---------------------------------------------------------------------------
  // line predictor: bresenham walk from start to end, one beat per pixel

  function automatic void trace_line(lrc_seg_in_t s);
    int       x, y, xe, ye, dx, ndy, sx, sy, err, e2, wlim, hlim;
    lrc_pix_t p;
    x    = s.start_x;
    y    = s.start_y;
    xe   = s.end_x;
    ye   = s.end_y;
    dx   = (xe > x) ? xe - x : x - xe;
    ndy  = (ye > y) ? y - ye : ye - y;     // minus |dy|
    sx   = (x < xe) ? 1 : -1;
    sy   = (y < ye) ? 1 : -1;
    err  = dx + ndy;
    // register values above the canvas size clamp to it
    wlim = (canvas_w > MaxCanvas) ? MaxCanvas : canvas_w;
    hlim = (canvas_h > MaxCanvas) ? MaxCanvas : canvas_h;
    for (int n = 0; n < MaxPixels; n++) begin
      p.pixel_x    = coord_t'(x);
      p.pixel_y    = coord_t'(y);
      p.visible    = (x < wlim) && (y < hlim);
      p.last_pixel = (x == xe) && (y == ye);
      pending_pix_q.push_back(p);
      if (p.last_pixel) break;
      e2 = 2 * err;
      // x and y moves both test the error from before this step
      if (e2 >= ndy) begin
        err += ndy;
        x   += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y   += sy;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 63) return coord_t'(63);
    return coord_t'(v);
  endfunction

  // canvas setting, extremes weighted in
  function automatic logic [CfgW-1:0] pick_extent();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CfgW'(1);
      2: return CfgW'(64);
      3: return CfgW'(127);
      4: return CfgW'($urandom_range(1, 64));
      default: return CfgW'($urandom_range(0, 127));
    endcase
  endfunction

  // segment shapes: points, axis lines, diagonals, short lines, anything
  function automatic lrc_seg_in_t rand_segment();
    lrc_seg_in_t s;
    int          len;
    s.start_x = coord_t'($urandom());
    s.start_y = coord_t'($urandom());
    s.end_x   = coord_t'($urandom());
    s.end_y   = coord_t'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
      1: s.end_y = s.start_y;
      2: s.end_x = s.start_x;
      3: begin
        len     = $urandom_range(0, 63);
        s.end_x = clamp_coord(int'(s.start_x) + ($urandom_range(0, 1) ? len : -len));
        s.end_y = clamp_coord(int'(s.start_y) + ($urandom_range(0, 1) ? len : -len));
      end
      4, 5: begin
        s.end_x = clamp_coord(int'(s.start_x) + int'($urandom_range(0, 14)) - 7);
        s.end_y = clamp_coord(int'(s.start_y) + int'($urandom_range(0, 14)) - 7);
      end
      default: ;
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks: each is entered and left at a falling edge

  // one segment beat; more says the next segment may follow without dropping valid
  task automatic offer_segment(lrc_seg_in_t s, logic typed, lrc_pix_t typed_pix, bit more);
    if (!valid_held) repeat (gap_ahead) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: book the pixels it owes
    if (typed) pending_pix_q.push_back(typed_pix);
    else trace_line(s);
    @(negedge clk_i);
    gap_ahead  = idle_cycles();
    valid_held = more && (gap_ahead == 0);
    if (!valid_held) in_valid_i <= 1'b0;
  endtask

  // sender holds still until every owed pixel beat has come out
  task automatic wait_drained();
    while (pending_pix_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // apb write: setup phase, then access phase; upper data bits are junk the dut drops
  task automatic write_canvas(lrc_reg_e sel, logic [CfgW-1:0] v);
    logic [DataW-1:0] junk;
    junk    = $urandom();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= {junk[DataW-1:CfgW], v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_CANVAS_WIDTH) canvas_w = v;
    else canvas_h = v;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(string name, logic [7:0] w, logic [7:0] g);
    if (w !== g) begin
      fail_count++;
      if (fail_count <= MaxReports)
        $display("%0t: %s expected %0d got %0d", $time, name, w, g);
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: compare each accepted pixel beat with the oldest owed one

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_taken++;
      if (pending_pix_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: pixel beat expected none got (%0d,%0d) vis %0b last %0b", $time,
                   out_data_o.pixel_x, out_data_o.pixel_y, out_data_o.visible,
                   out_data_o.last_pixel);
      end else begin
        want = pending_pix_q.pop_front();
        check_field("pixel_x", want.pixel_x, out_data_o.pixel_x);
        check_field("pixel_y", want.pixel_y, out_data_o.pixel_y);
        check_field("visible", want.visible, out_data_o.visible);
        check_field("last_pixel", want.last_pixel, out_data_o.last_pixel);
      end
    end
  end

  // sink readiness: ready bursts broken by random idle stretches, and one long
  // hold-off that lets the segment queue fill and push back on the input
  initial begin : sink_pacing
    int unsigned run_len;
    int unsigned idle_len;
    bit          long_done;
    long_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_done && beats_taken >= LongStallAfter) begin
        long_done = 1'b1;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (LongStallCycles - 1) @(negedge clk_i);
      end
      run_len  = $urandom_range(1, 30);
      idle_len = idle_cycles();
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (run_len - 1) @(negedge clk_i);
      if (idle_len > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (idle_len - 1) @(negedge clk_i);
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin : stimulus
    bit more;
    // every input known from time zero
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    canvas_w   = CfgW'(64);
    canvas_h   = CfgW'(64);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table; register writes only once the dut has emptied
    for (int i = 0; i < DirRows; i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        wait_drained();
        write_canvas(dir_table[i].reg_sel, dir_table[i].value);
      end else begin
        more = (i + 1 < DirRows) && (dir_table[i + 1].kind == ROW_SEG);
        offer_segment(dir_table[i].seg, dir_table[i].typed, dir_table[i].pix, more);
      end
    end

    // random phases, each with its own canvas setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      write_canvas(REG_CANVAS_WIDTH, pick_extent());
      // the bus returns to idle between the two writes
      @(negedge clk_i);
      write_canvas(REG_CANVAS_HEIGHT, pick_extent());
      for (int k = 0; k < PhaseItems; k++) begin
        // halfway through one phase the sender waits for the output to run dry
        if (ph == PausePhase && k == PhaseItems / 2) wait_drained();
        more = (k + 1 < PhaseItems) && !(ph == PausePhase && k + 1 == PhaseItems / 2);
        offer_segment(rand_segment(), 1'b0, '0, more);
      end
    end

    wait_drained();
    repeat (EndSettle) @(posedge clk_i);
    if (fail_count == 0 && pending_pix_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lrc_pkg.sv
design/lrc_front.sv
design/lrc_queue.sv
design/lrc_back.sv
design/line_rasterizer_with_clip_unit.sv
sim/line_rasterizer_with_clip_unit_tb.sv
